// ----- design/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and constants for the integer to decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned BcdW    = 4 * NumDig;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CharW   = 8;

  localparam logic [IdxW-1:0]  TopIdx   = IdxW'(NumDig - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(ValueW - 1);

  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [3:0]       ChDigHi = 4'h3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new value, clear the bcd word
    logic step;       // one shift-add-3 step
    logic dec_idx;    // move to the next lower digit
    logic put_sign;   // load '-' into the output register
    logic put_digit;  // load the current digit into the output register
  } itda_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic neg;
    logic step_last;
    logic digit_zero;
    logic idx_zero;
  } itda_sts_t;

endpackage

`default_nettype wire

// ----- design/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per word
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one signed 32-bit value per word on s_tdata_i.
//   master side returns its decimal text, most significant character
//   first: an optional '-' and then the digits without leading zeros.
//   m_tlast_o is high on the final digit. zero gives the single "0".
//   sequence: the accept cycle, 32 double-dabble steps in the bcd
//   register, a skip phase over the leading zero digits, then one
//   character per cycle while the receiver is ready.
//   s_tready_o is high only between items. the next value may be taken
//   while the last character still waits in the output register.
//   a stalled receiver holds the output word and pauses the emit phase.
//   reset empties the output register and returns to waiting for input.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii
  import itda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire logic [ValueW-1:0] s_tdata_i,   // [31:0] value
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output logic [CharW-1:0]       m_tdata_o,   // [7:0] text_char
  output logic                   m_tlast_o
);

  itda_cmd_t cmd;
  itda_sts_t sts;

  itda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itda_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .text_char_o (m_tdata_o),
    .last_char_o (m_tlast_o)
  );

endmodule

`default_nettype wire

// ----- design/itda_datapath.sv -----
// ----------------------------------------------------------------------------
// itda_datapath
// magnitude, double-dabble bcd register, digit pointer and output word
// ----------------------------------------------------------------------------
`default_nettype none

module itda_datapath
  import itda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] value_i,
  input  wire itda_cmd_t         cmd_i,
  output itda_sts_t              sts_o,
  output logic [CharW-1:0]       text_char_o,
  output logic                   last_char_o
);

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_adj;
  logic              neg_q, neg_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic [3:0]        digit;

  // add 3 to every nibble of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < NumDig; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  assign digit = bcd_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      neg_d = value_i[ValueW-1];
      mag_d = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      bcd_d = '0;
      cnt_d = '0;
      idx_d = TopIdx;
    end
    if (cmd_i.step) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + StepW'(1);
    end
    if (cmd_i.dec_idx) begin
      idx_d = idx_q - IdxW'(1);
    end
    if (cmd_i.put_sign) begin
      char_d = ChMinus;
      last_d = 1'b0;
    end
    if (cmd_i.put_digit) begin
      char_d = {ChDigHi, digit};
      last_d = (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign sts_o.neg        = neg_q;
  assign sts_o.step_last  = (cnt_q == LastStep);
  assign sts_o.digit_zero = (digit == 4'd0);
  assign sts_o.idx_zero   = (idx_q == '0);

  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

// ----- design/itda_ctrl.sv -----
// ----------------------------------------------------------------------------
// itda_ctrl
// sequencer: accept, convert, skip leading zeros, emit sign and digits
// ----------------------------------------------------------------------------
`default_nettype none

module itda_ctrl
  import itda_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire itda_sts_t sts_i,
  output itda_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       slot_free;

  assign slot_free = !oval_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.digit_zero && !sts_i.idx_zero) begin
          cmd_o.dec_idx = 1'b1;
        end else begin
          state_d = sts_i.neg ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          cmd_o.put_sign = 1'b1;
          state_d        = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.put_digit = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = StIdle;
          end else begin
            cmd_o.dec_idx = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    oval_d = oval_q && !out_ready_i;
    if (cmd_o.put_sign || cmd_o.put_digit) begin
      oval_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = oval_q;

  a_sign_only_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.put_sign |-> sts_i.neg)
    else $error("sign emitted for a non-negative value");

  a_no_put_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !out_ready_i) |-> !(cmd_o.put_sign || cmd_o.put_digit))
    else $error("output word overwritten while stalled");

  a_final_digit_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.put_digit && sts_i.idx_zero) |=> (state_q == StIdle))
    else $error("no return to idle after final digit");

  a_load_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == StIdle))
    else $error("value loaded outside idle");

endmodule

`default_nettype wire
